/* rtl/tsrs_pkg.sv */
`default_nettype none
package tsrs_pkg;

  localparam int RECS        = 128;  // records per sector
  localparam int MAX_IDS     = 32;
  localparam int VALUE_BYTES = 8;

  localparam int NREC   = 2 * RECS;
  localparam int ADDR_W = $clog2(NREC);
  localparam int CNT_W  = $clog2(RECS + 1);
  localparam int ID_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int KW     = $clog2(MAX_IDS + 1);
  localparam int VAL_W  = 64;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_GET   = 2'd2;
  localparam logic [1:0] MODE_ERASE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] SEC_EMPTY   = 2'd0;
  localparam logic [1:0] SEC_INIT    = 2'd1;
  localparam logic [1:0] SEC_VALID   = 2'd2;
  localparam logic [1:0] SEC_INVALID = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CMP      = 8'b0000_0010,
    S_WR       = 8'b0000_0100,
    S_CPY_CHK  = 8'b0000_1000,
    S_CPY_WR   = 8'b0001_0000,
    S_WALK_ISS = 8'b0010_0000,
    S_WALK_UPD = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  // record address of a slot in a sector
  function automatic logic [ADDR_W-1:0] rec_addr(input logic sec, input logic [CNT_W-1:0] slot);
    rec_addr = (sec ? ADDR_W'(RECS) : ADDR_W'(0)) + ADDR_W'(slot);
  endfunction

endpackage
`default_nettype wire

/* rtl/two_sector_record_store.sv */
`default_nettype none
// Two-sector record store: variables live as records appended to one of two
// sectors of a 2 x 128 record memory; a per-id table points at each id's latest
// record. Modes: init/recover, set, get, erase-all. One word in, one word out.
// Get and unchanged set pass the id table, one registered memory read and a
// compare; a set that writes adds a write. Init and erase walk the active
// sector, one read and one table update per stored record, to the first free
// slot. A set that finds the sector full first compacts: a check and a copy per
// live id, a check per other id, then the walkless finish. The memory's one
// read and one write port pace all of it. The block takes no new word while an
// operation runs; a finished result sits in the output register so the next
// word may be taken before it is drained. Erasure clears per-record written flags.
module two_sector_record_store (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [4:0]  in_var_id,
  input  wire logic [63:0] in_value,
  input  wire logic [3:0]  in_byte_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_read_value,
  output logic             out_record_written,
  output logic             out_compacted,
  output logic             out_active_sector,
  output logic [7:0]       out_used_records
);
  import tsrs_pkg::*;

  // record memory
  logic [VAL_W-1:0] val_mem [NREC];
  logic [ID_W-1:0]  id_mem  [NREC];
  logic [VAL_W-1:0] rd_val_r;
  logic [ID_W-1:0]  rd_id_r;
  logic [NREC-1:0]  vld_r, vld_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] wa, ra;
  logic [VAL_W-1:0]  wd;
  logic [ID_W-1:0]   wid;

  // id table
  logic [MAX_IDS-1:0] lk_vld_r, lk_vld_nxt;
  logic [CNT_W-1:0]   lk_slot_r [MAX_IDS];
  logic [CNT_W-1:0]   lk_slot_nxt [MAX_IDS];

  state_t           state_r, state_nxt;
  logic [1:0]       sec0_r, sec0_nxt, sec1_r, sec1_nxt;
  logic             cur_r, cur_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;

  // item being worked on
  logic [1:0]       mode_r, mode_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [7:0]       mask_r, mask_nxt;
  logic             pres_r, pres_nxt;
  logic             idok_r, idok_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;      // walk slot / compaction dest
  logic [KW-1:0]    k_r, k_nxt;      // compaction id

  logic [1:0]       res_st_r, res_st_nxt;
  logic [VAL_W-1:0] res_rd_r, res_rd_nxt;
  logic             res_wr_r, res_wr_nxt, res_sw_r, res_sw_nxt;

  logic             ov_r;
  logic [1:0]       ost_r;
  logic [VAL_W-1:0] ord_r;
  logic             owr_r, osw_r, osec_r;
  logic [CNT_W-1:0] oused_r;
  logic             load_out;

  logic             er0, er1;
  logic [3:0]       cnt_c;
  logic [7:0]       mask_c;
  logic [VAL_W-1:0] bmask, pad;
  logic [ID_W-1:0]  in_idx;
  logic             in_idok;
  logic [1:0]       s0, s1;
  logic [ADDR_W-1:0] walk_a;

  assign in_ready = (state_r == S_IDLE);
  assign in_idok  = ({3'b0, in_var_id} < 8'(MAX_IDS));
  assign in_idx   = ID_W'(in_var_id);
  assign cnt_c    = (in_byte_count > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : in_byte_count;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask_c[b] = (4'(b) < cnt_c);
      bmask[b*8 +: 8] = {8{mask_r[b]}};
    end
  end
  assign pad    = (val_r & bmask) | ~bmask;
  assign walk_a = rec_addr(cur_r, i_r);

  always_comb begin
    state_nxt   = state_r;
    sec0_nxt    = sec0_r;
    sec1_nxt    = sec1_r;
    cur_nxt     = cur_r;
    free_nxt    = free_r;
    mode_nxt    = mode_r;
    id_nxt      = id_r;
    val_nxt     = val_r;
    mask_nxt    = mask_r;
    pres_nxt    = pres_r;
    idok_nxt    = idok_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    res_st_nxt  = res_st_r;
    res_rd_nxt  = res_rd_r;
    res_wr_nxt  = res_wr_r;
    res_sw_nxt  = res_sw_r;
    lk_vld_nxt  = lk_vld_r;
    lk_slot_nxt = lk_slot_r;
    er0 = 1'b0;
    er1 = 1'b0;
    mem_we = 1'b0;
    wa  = rec_addr(cur_r, free_r);
    wd  = pad;
    wid = id_r;
    ra  = rec_addr(cur_r, lk_slot_r[in_idx]);
    s0  = sec0_r;
    s1  = sec1_r;
    load_out = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          id_nxt     = in_idx;
          val_nxt    = in_value;
          mask_nxt   = mask_c;
          idok_nxt   = in_idok;
          pres_nxt   = in_idok && lk_vld_r[in_idx];
          res_st_nxt = ST_OK;
          res_rd_nxt = '0;
          res_wr_nxt = 1'b0;
          res_sw_nxt = 1'b0;
          i_nxt      = '0;
          unique case (in_mode)
            MODE_INIT: begin
              if (s0 != SEC_EMPTY && s0 != SEC_VALID) begin
                er0 = 1'b1;
                s0  = SEC_EMPTY;
              end
              if (s1 != SEC_EMPTY && s1 != SEC_VALID) begin
                er1 = 1'b1;
                s1  = SEC_EMPTY;
              end
              if (s0 == SEC_EMPTY) begin
                if (s1 == SEC_EMPTY) begin
                  s0 = SEC_VALID;
                  cur_nxt = 1'b0;
                end else begin
                  cur_nxt = 1'b1;
                end
              end else begin
                if (s1 == SEC_VALID) begin
                  er1 = 1'b1;
                  s1  = SEC_EMPTY;
                end
                cur_nxt = 1'b0;
              end
              sec0_nxt   = s0;
              sec1_nxt   = s1;
              lk_vld_nxt = '0;
              state_nxt  = S_WALK_ISS;
            end
            MODE_ERASE: begin
              er0 = 1'b1;
              er1 = 1'b1;
              sec0_nxt   = SEC_VALID;
              sec1_nxt   = SEC_EMPTY;
              cur_nxt    = 1'b0;
              lk_vld_nxt = '0;
              state_nxt  = S_WALK_ISS;
            end
            default: state_nxt = S_CMP;   // set, get: stored word read in flight
          endcase
        end
      end

      S_CMP: begin
        if (mode_r == MODE_GET) begin
          if (pres_r) begin
            res_rd_nxt = (rd_val_r & bmask) | ~bmask;
          end else begin
            res_rd_nxt = '1;
            res_st_nxt = ST_NOTFOUND;
          end
          state_nxt = S_FIN;
        end else if (!idok_r || mask_r == 8'd0 ||
                     (pres_r && ((rd_val_r ^ val_r) & bmask) == '0)) begin
          state_nxt = S_FIN;              // unchanged, empty or out-of-range id
        end else if (free_r >= CNT_W'(RECS)) begin
          res_sw_nxt = 1'b1;
          if (cur_r) begin
            if (sec0_r != SEC_EMPTY) er0 = 1'b1;
            sec0_nxt = SEC_INIT;
          end else begin
            if (sec1_r != SEC_EMPTY) er1 = 1'b1;
            sec1_nxt = SEC_INIT;
          end
          k_nxt     = '0;
          i_nxt     = '0;
          state_nxt = S_CPY_CHK;
        end else begin
          state_nxt = S_WR;
        end
      end

      S_CPY_CHK: begin
        ra = rec_addr(cur_r, lk_slot_r[ID_W'(k_r)]);
        if (k_r == KW'(MAX_IDS)) begin
          if (cur_r) begin
            sec0_nxt = SEC_VALID;
            sec1_nxt = SEC_INVALID;
          end else begin
            sec1_nxt = SEC_VALID;
            sec0_nxt = SEC_INVALID;
          end
          cur_nxt  = ~cur_r;
          free_nxt = i_r;
          if (i_r >= CNT_W'(RECS)) begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_WR;
          end
        end else if (lk_vld_r[ID_W'(k_r)] && i_r < CNT_W'(RECS)) begin
          state_nxt = S_CPY_WR;
        end else begin
          lk_vld_nxt[ID_W'(k_r)] = 1'b0;
          k_nxt = k_r + KW'(1);
        end
      end

      S_CPY_WR: begin
        mem_we = 1'b1;
        wa  = rec_addr(~cur_r, i_r);
        wd  = rd_val_r;
        wid = rd_id_r;
        lk_slot_nxt[ID_W'(k_r)] = i_r;
        i_nxt     = i_r + CNT_W'(1);
        k_nxt     = k_r + KW'(1);
        state_nxt = S_CPY_CHK;
      end

      S_WR: begin
        mem_we = 1'b1;
        lk_vld_nxt[id_r]  = 1'b1;
        lk_slot_nxt[id_r] = free_r;
        free_nxt   = free_r + CNT_W'(1);
        res_wr_nxt = 1'b1;
        state_nxt  = S_FIN;
      end

      S_WALK_ISS: begin
        ra = walk_a;
        if (i_r >= CNT_W'(RECS) || !vld_r[walk_a]) begin
          free_nxt  = i_r;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WALK_UPD;
        end
      end

      S_WALK_UPD: begin
        lk_vld_nxt[rd_id_r]  = 1'b1;
        lk_slot_nxt[rd_id_r] = i_r;
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_WALK_ISS;
      end

      S_FIN: begin
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // written flags: sector erase clears, a write sets
    vld_nxt = vld_r;
    for (int j = 0; j < NREC; j++) begin
      if ((er0 && j < RECS) || (er1 && j >= RECS)) vld_nxt[j] = 1'b0;
    end
    if (mem_we) vld_nxt[wa] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[wa] <= wd;
      id_mem[wa]  <= wid;
    end
    rd_val_r <= val_mem[ra];
    rd_id_r  <= id_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vld_r    <= '0;
      lk_vld_r <= '0;
      sec0_r   <= SEC_VALID;
      sec1_r   <= SEC_EMPTY;
      cur_r    <= 1'b0;
      free_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      vld_r    <= vld_nxt;
      lk_vld_r <= lk_vld_nxt;
      sec0_r   <= sec0_nxt;
      sec1_r   <= sec1_nxt;
      cur_r    <= cur_nxt;
      free_r   <= free_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lk_slot_r <= lk_slot_nxt;
    mode_r    <= mode_nxt;
    id_r      <= id_nxt;
    val_r     <= val_nxt;
    mask_r    <= mask_nxt;
    pres_r    <= pres_nxt;
    idok_r    <= idok_nxt;
    i_r       <= i_nxt;
    k_r       <= k_nxt;
    res_st_r  <= res_st_nxt;
    res_rd_r  <= res_rd_nxt;
    res_wr_r  <= res_wr_nxt;
    res_sw_r  <= res_sw_nxt;
    if (load_out) begin
      ost_r   <= res_st_r;
      ord_r   <= res_rd_r;
      owr_r   <= res_wr_r;
      osw_r   <= res_sw_r;
      osec_r  <= cur_r;
      oused_r <= free_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_read_value     = ord_r;
  assign out_record_written = owr_r;
  assign out_compacted      = osw_r;
  assign out_active_sector  = osec_r;
  assign out_used_records   = 8'(oused_r);

endmodule
`default_nettype wire
